/* sv/nlej_pkg.sv */
package nlej_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W = 31;
    localparam int VAL_W = 32;
    localparam int TOTAL_W = 32;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_STORE = 2'd1,
        OP_PROBE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic clear;
        logic store;
        logic probe_load;
        logic rd_en;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic scan_end;
    } status_t;

endpackage

/* sv/nested_loop_equi_join_core.sv */
// Nested-loop equality join: clear and store items finish without leaving idle, while a probe
// item holds busy through a scan of the stored rows and a flush, because the stored table sits in
// a single-port memory that is read one row per cycle and each row is compared in turn. A
// probe gives one result per equal row in stored order, or a single result with matched low
// when nothing is equal. Each result appears for exactly one cycle with result_valid high,
// and the receiver cannot stall the block, so it must take every result as it comes.
module nested_loop_equi_join_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           opcode,
    input  logic [nlej_pkg::POS_W-1:0]           row_position,
    input  logic signed [nlej_pkg::VAL_W-1:0]    row_value,
    input  logic                                 cfg_we,
    input  logic                                 cfg_wdata,
    output logic                                 result_valid,
    output logic [nlej_pkg::POS_W-1:0]           first_position,
    output logic [nlej_pkg::POS_W-1:0]           second_position,
    output logic                                 matched,
    output logic                                 last,
    output logic [nlej_pkg::TOTAL_W-1:0]         match_total
);

    nlej_pkg::cmd_t    cmd;
    nlej_pkg::status_t status;

    nlej_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .opcode  (opcode),
        .status  (status),
        .busy    (busy),
        .cmd     (cmd)
    );

    nlej_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .row_position    (row_position),
        .row_value       (row_value),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .status          (status),
        .result_valid    (result_valid),
        .first_position  (first_position),
        .second_position (second_position),
        .matched         (matched),
        .last            (last),
        .match_total     (match_total)
    );

endmodule

/* sv/nlej_ctrl.sv */
module nlej_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         opcode,
    input  nlej_pkg::status_t  status,
    output logic               busy,
    output nlej_pkg::cmd_t     cmd
);

    nlej_pkg::state_t state_reg;
    nlej_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nlej_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        unique case (state_reg)
            nlej_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    unique case (opcode)
                        nlej_pkg::OP_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        nlej_pkg::OP_STORE:
                        begin
                            cmd.store = 1'b1;
                        end
                        nlej_pkg::OP_PROBE:
                        begin
                            cmd.probe_load = 1'b1;
                            state_next = nlej_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            state_next = nlej_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            nlej_pkg::ST_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = nlej_pkg::ST_FLUSH;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            nlej_pkg::ST_FLUSH:
            begin
                cmd.flush = 1'b1;
                state_next = nlej_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = nlej_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/nlej_datapath.sv */
module nlej_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  nlej_pkg::cmd_t                       cmd,
    input  logic [nlej_pkg::POS_W-1:0]           row_position,
    input  logic signed [nlej_pkg::VAL_W-1:0]    row_value,
    input  logic                                 cfg_we,
    input  logic                                 cfg_wdata,
    output nlej_pkg::status_t                    status,
    output logic                                 result_valid,
    output logic [nlej_pkg::POS_W-1:0]           first_position,
    output logic [nlej_pkg::POS_W-1:0]           second_position,
    output logic                                 matched,
    output logic                                 last,
    output logic [nlej_pkg::TOTAL_W-1:0]         match_total
);

    localparam int ROW_W = nlej_pkg::POS_W + nlej_pkg::VAL_W;

    logic [ROW_W-1:0] inner_mem [nlej_pkg::TABLE_DEPTH];

    logic                            outer_is_first_reg;
    logic [nlej_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [nlej_pkg::TOTAL_W-1:0]    total_reg, total_next;
    logic [nlej_pkg::CNT_W-1:0]      idx_reg, idx_next;
    logic [nlej_pkg::POS_W-1:0]      key_pos_reg, key_pos_next;
    logic [nlej_pkg::VAL_W-1:0]      key_val_reg, key_val_next;
    logic [ROW_W-1:0]                rd_data_reg;
    logic                            rd_valid_reg;
    logic [nlej_pkg::POS_W-1:0]      pend_pos_reg, pend_pos_next;
    logic                            pend_valid_reg, pend_valid_next;

    logic                            out_valid_reg, out_valid_next;
    logic [nlej_pkg::POS_W-1:0]      out_first_reg, out_first_next;
    logic [nlej_pkg::POS_W-1:0]      out_second_reg, out_second_next;
    logic                            out_matched_reg, out_matched_next;
    logic                            out_last_reg, out_last_next;
    logic [nlej_pkg::TOTAL_W-1:0]    out_total_reg, out_total_next;

    logic                            table_full;
    logic                            hit;
    logic                            emit_match;
    logic                            emit_empty;
    logic [nlej_pkg::TOTAL_W-1:0]    total_inc;
    logic [nlej_pkg::POS_W-1:0]      inner_pos;

    assign table_full = (count_reg >= nlej_pkg::CNT_W'(nlej_pkg::TABLE_DEPTH));
    assign status.scan_end = (idx_reg >= count_reg);
    assign hit = rd_valid_reg
        && (rd_data_reg[nlej_pkg::VAL_W-1:0] == key_val_reg);
    assign emit_match = pend_valid_reg && (hit || cmd.flush);
    assign emit_empty = cmd.flush && !pend_valid_reg;
    assign total_inc = (total_reg == '1) ? total_reg : total_reg + 1'b1;
    assign inner_pos = emit_match ? pend_pos_reg : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.store && !table_full)
        begin
            inner_mem[count_reg[nlej_pkg::ADDR_W-1:0]] <= {row_position, row_value};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= inner_mem[idx_reg[nlej_pkg::ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        total_next = total_reg;
        idx_next = idx_reg;
        key_pos_next = key_pos_reg;
        key_val_next = key_val_reg;
        pend_pos_next = pend_pos_reg;
        pend_valid_next = pend_valid_reg;

        if (cmd.clear)
        begin
            count_next = '0;
            total_next = '0;
        end
        if (cmd.store && !table_full)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.probe_load)
        begin
            key_pos_next = row_position;
            key_val_next = row_value;
            idx_next = '0;
            pend_valid_next = 1'b0;
        end
        if (cmd.rd_en)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (emit_match)
        begin
            total_next = total_inc;
        end
        if (hit)
        begin
            pend_pos_next = rd_data_reg[ROW_W-1:nlej_pkg::VAL_W];
            pend_valid_next = 1'b1;
        end

        out_valid_next = emit_match || emit_empty;
        out_matched_next = emit_match;
        out_last_next = cmd.flush;
        out_total_next = emit_match ? total_inc : total_reg;
        out_first_next = outer_is_first_reg ? key_pos_reg : inner_pos;
        out_second_next = outer_is_first_reg ? inner_pos : key_pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_is_first_reg <= 1'b1;
            count_reg <= '0;
            total_reg <= '0;
            idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                outer_is_first_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            total_reg <= total_next;
            idx_reg <= idx_next;
            rd_valid_reg <= cmd.rd_en;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_pos_reg <= key_pos_next;
        key_val_reg <= key_val_next;
        pend_pos_reg <= pend_pos_next;
        out_first_reg <= out_first_next;
        out_second_reg <= out_second_next;
        out_matched_reg <= out_matched_next;
        out_last_reg <= out_last_next;
        out_total_reg <= out_total_next;
    end

    assign result_valid = out_valid_reg;
    assign first_position = out_first_reg;
    assign second_position = out_second_reg;
    assign matched = out_matched_reg;
    assign last = out_last_reg;
    assign match_total = out_total_reg;

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_matched_reg) |-> out_last_reg)
        else $error("Empty probe result without last flag.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= nlej_pkg::CNT_W'(nlej_pkg::TABLE_DEPTH))
        else $error("Stored row count exceeds table depth.");

    a_match_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_matched_reg) |-> (out_total_reg != '0))
        else $error("Match result with zero total.");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (idx_reg < count_reg))
        else $error("Table read beyond stored rows.");

endmodule
